// ===== rtl/core/lz_tile_stream_expander_macros.svh =====
// Assertion macros shared by the checker of the tile stream expander.
`ifndef LZ_TILE_STREAM_EXPANDER_MACROS_SVH
`define LZ_TILE_STREAM_EXPANDER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define LZT_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("lzt check failed: same-cycle implication");

// Next-cycle implication, ignored while reset is high.
`define LZT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("lzt check failed: next-cycle implication");

`endif

// ===== rtl/core/lzt_pkg.sv =====
// Types and constants shared by the tile stream expander modules.
`default_nettype none
package lzt_pkg;

  localparam int DICT_TILES_DEF  = 512;
  localparam int MAX_TILES_DEF   = 1024;
  localparam int PLANE_COUNT_DEF = 4;

  localparam int POS_W  = 11;  // tile position, covers MAX_TILES plus one copy run
  localparam int DCNT_W = 10;  // dictionary size from the header, up to 512

  localparam logic [15:0] VRAM_BASE  = 16'h8000;
  localparam logic [15:0] ROW_TOP    = 16'd255;

  typedef enum logic [2:0] {
    OP_HDR   = 3'd0,
    OP_DICT  = 3'd1,
    OP_LIT   = 3'd2,
    OP_REF   = 3'd3,
    OP_PLANE = 3'd4,
    OP_DONE  = 3'd5,
    OP_EOB   = 3'd6
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [8:0]        idx;
    logic              bad;
    logic [11:0]       offset;
    logic [4:0]        len;
    logic [8:0]        entry;
    logic [63:0]       data;
    logic [POS_W-1:0]  tpp;
    logic [7:0]        height;
  } cmd_t;

  typedef struct packed {
    logic        is_write;
    logic [15:0] tile_address;
    logic [63:0] tile_data;
    logic        bad_token;
    logic        blob_done;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/lz_tile_stream_expander.sv =====
// Top level of the compressed tile stream expander.
`default_nettype none
// Takes a compressed tile blob one byte per transaction (blob_start marks the
// first header byte) and produces 8-byte tile writes with their column-major
// VRAM addresses, then one done result. A byte is taken whenever the command
// queue has room and the parser is not settling or finishing; after a token
// byte the parser sends a plane command for each finished plane and then a
// command that closes the byte (with a done command before it when the blob ends).
// The executor takes each command in turn; each tile write then goes through a
// position check, a dictionary read and an emit, which waits while the result
// queue is full, and a copied tile adds a history memory read; skipped
// positions take only the position check. A reference token therefore holds
// the executor for its whole copy run, absorbed by the 4-entry command and
// result queues. The last result of a byte is flagged once the byte's closing
// command reaches the executor. No clearing pass is needed after reset.
module lz_tile_stream_expander
  import lzt_pkg::*;
#(
  parameter int DICT_TILES  = DICT_TILES_DEF,
  parameter int MAX_TILES   = MAX_TILES_DEF,
  parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  data_byte,
  input  wire logic        blob_start,
  input  wire logic        push,
  output logic             full,
  output logic             empty,
  input  wire logic        pop,
  output logic             is_write,
  output logic [15:0]      tile_address,
  output logic [63:0]      tile_data,
  output logic             bad_token,
  output logic             blob_done,
  output logic             last
);
  cmd_t    cmd_in, cmd_out;
  logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
  result_t res_in, res_out;
  logic    res_push, res_full;

  // front: parser and plane sequencer
  lzt_front #(
    .MAX_TILES  (MAX_TILES),
    .DICT_TILES (DICT_TILES),
    .PLANE_COUNT(PLANE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .blob_start(blob_start),
    .in_push   (push),
    .in_full   (full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .cmd_full  (cmd_full)
  );

  // decoupling queue between parser and executor
  lzt_fifo #(.WIDTH($bits(cmd_t)), .DEPTH_LOG2(2)) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .din  (cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .dout (cmd_out),
    .empty(cmd_empty)
  );

  // back: memories and tile write generation
  lzt_back #(
    .DICT_TILES(DICT_TILES),
    .MAX_TILES (MAX_TILES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_out),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .out_push (res_push),
    .out_res  (res_in),
    .out_full (res_full)
  );

  // result queue; its head drives the result ports
  lzt_fifo #(.WIDTH($bits(result_t)), .DEPTH_LOG2(2)) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (pop),
    .dout (res_out),
    .empty(empty)
  );

  assign is_write     = res_out.is_write;
  assign tile_address = res_out.tile_address;
  assign tile_data    = res_out.tile_data;
  assign bad_token    = res_out.bad_token;
  assign blob_done    = res_out.blob_done;
  assign last         = res_out.last;
endmodule
`default_nettype wire

// ===== rtl/core/lzt_fifo.sv =====
// Small register queue used for commands and for results.
`default_nettype none
module lzt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH_LOG2 = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);
  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]      mem [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr;
  logic [DEPTH_LOG2-1:0] rd_ptr;
  logic [DEPTH_LOG2:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == (DEPTH_LOG2+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end
endmodule
`default_nettype wire

// ===== rtl/core/lzt_front.sv =====
// Byte parser: header, dictionary assembly, flag/token decode, plane sequencing.
`default_nettype none
module lzt_front
  import lzt_pkg::*;
#(
  parameter int MAX_TILES   = MAX_TILES_DEF,
  parameter int DICT_TILES  = DICT_TILES_DEF,
  parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] data_byte,
  input  wire logic       blob_start,
  input  wire logic       in_push,
  output logic            in_full,
  output logic            cmd_push,
  output cmd_t            cmd,
  input  wire logic       cmd_full
);
  typedef enum logic [11:0] {
    F_IDLE   = 12'b0000_0000_0001,
    F_H1     = 12'b0000_0000_0010,
    F_H2     = 12'b0000_0000_0100,
    F_H3     = 12'b0000_0000_1000,
    F_H4     = 12'b0000_0001_0000,
    F_DICT   = 12'b0000_0010_0000,
    F_FLAG   = 12'b0000_0100_0000,
    F_TOK0   = 12'b0000_1000_0000,
    F_TOK1   = 12'b0001_0000_0000,
    F_SETTLE = 12'b0010_0000_0000,
    F_FIN    = 12'b0100_0000_0000,
    F_DONE   = 12'b1000_0000_0000
  } fstate_t;

  fstate_t           state, state_next;
  logic [POS_W-1:0]  tpp, tpp_next;
  logic [DCNT_W-1:0] dcnt, dcnt_next;
  logic [12:0]       lc, lc_next;
  logic [63:0]       word, word_next;
  logic [7:0]        fbits, fbits_next;
  logic [3:0]        fcnt, fcnt_next;
  logic [7:0]        first, first_next;
  logic [POS_W-1:0]  fpos, fpos_next;
  logic [1:0]        plane, plane_next;

  logic        take;
  logic [15:0] hv;
  logic [8:0]  lit_idx;
  logic [13:0] lc_inc;

  assign in_full = cmd_full || (state == F_SETTLE) || (state == F_FIN);
  assign take    = in_push && !in_full;
  assign hv      = {data_byte, tpp[7:0]};
  assign lit_idx = {first[0], data_byte};
  assign lc_inc  = {1'b0, lc} + 14'd1;

  always_comb begin
    state_next = state;
    tpp_next   = tpp;
    dcnt_next  = dcnt;
    lc_next    = lc;
    word_next  = word;
    fbits_next = fbits;
    fcnt_next  = fcnt;
    first_next = first;
    fpos_next  = fpos;
    plane_next = plane;
    cmd_push   = 1'b0;
    cmd        = '0;
    if (take && blob_start) begin
      tpp_next   = {{(POS_W-8){1'b0}}, data_byte};
      state_next = F_H1;
    end else if (take) begin
      unique case (state)
        F_H1: begin
          tpp_next   = (hv > 16'(MAX_TILES)) ? POS_W'(MAX_TILES) : hv[POS_W-1:0];
          state_next = F_H2;
        end
        F_H2: begin
          dcnt_next  = {{(DCNT_W-8){1'b0}}, data_byte};
          state_next = F_H3;
        end
        F_H3: begin
          dcnt_next  = ({data_byte, dcnt[7:0]} > 16'(DICT_TILES)) ? DCNT_W'(DICT_TILES)
                                                                   : {data_byte[1:0], dcnt[7:0]};
          state_next = F_H4;
        end
        F_H4: begin
          cmd_push   = 1'b1;
          cmd.op     = OP_HDR;
          cmd.tpp    = tpp;
          cmd.height = data_byte;
          lc_next    = '0;
          if (dcnt != '0) begin
            state_next = F_DICT;
          end else begin
            plane_next = '0;
            fpos_next  = '0;
            fcnt_next  = '0;
            state_next = F_SETTLE;
          end
        end
        F_DICT: begin
          word_next[{lc[2:0], 3'b000} +: 8] = data_byte;
          lc_next = lc_inc[12:0];
          if (lc[2:0] == 3'd7) begin
            cmd_push  = 1'b1;
            cmd.op    = OP_DICT;
            cmd.entry = lc[11:3];
            cmd.data  = word_next;
          end
          if (lc_inc >= {1'b0, dcnt, 3'b000}) begin
            plane_next = '0;
            fpos_next  = '0;
            fcnt_next  = '0;
            state_next = F_SETTLE;
          end
        end
        F_FLAG: begin
          fbits_next = data_byte;
          fcnt_next  = 4'd8;
          state_next = F_TOK0;
        end
        F_TOK0: begin
          first_next = data_byte;
          state_next = F_TOK1;
        end
        F_TOK1: begin
          cmd_push = 1'b1;
          if (fbits[0]) begin
            cmd.op    = OP_LIT;
            cmd.idx   = lit_idx;
            cmd.bad   = ({1'b0, lit_idx} >= dcnt);
            fpos_next = fpos + 1'b1;
          end else begin
            cmd.op     = OP_REF;
            cmd.offset = {first[3:0], data_byte};
            cmd.len    = {1'b0, first[7:4]} + 5'd3;
            fpos_next  = fpos + POS_W'({1'b0, first[7:4]} + 5'd3);
          end
          fbits_next = fbits >> 1;
          fcnt_next  = fcnt - 1'b1;
          state_next = F_SETTLE;
        end
        default: begin
        end
      endcase
    end else if (state == F_SETTLE && !cmd_full) begin
      cmd_push = 1'b1;
      if (fcnt != '0) begin
        cmd.op     = OP_EOB;
        state_next = F_TOK0;
      end else if (fpos < tpp) begin
        cmd.op     = OP_EOB;
        state_next = F_FLAG;
      end else if ({1'b0, plane} + 3'd1 >= 3'(PLANE_COUNT)) begin
        cmd.op     = OP_DONE;
        state_next = F_FIN;
      end else begin
        cmd.op     = OP_PLANE;
        plane_next = plane + 1'b1;
        fpos_next  = '0;
      end
    end else if (state == F_FIN && !cmd_full) begin
      cmd_push   = 1'b1;
      cmd.op     = OP_EOB;
      state_next = F_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      tpp   <= '0;
      dcnt  <= '0;
      lc    <= '0;
      fbits <= '0;
      fcnt  <= '0;
      first <= '0;
      fpos  <= '0;
      plane <= '0;
    end else begin
      state <= state_next;
      tpp   <= tpp_next;
      dcnt  <= dcnt_next;
      lc    <= lc_next;
      fbits <= fbits_next;
      fcnt  <= fcnt_next;
      first <= first_next;
      fpos  <= fpos_next;
      plane <= plane_next;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end
endmodule
`default_nettype wire

// ===== rtl/core/lzt_back.sv =====
// Command executor: dictionary and index history memories, tile write generation.
`default_nettype none
module lzt_back
  import lzt_pkg::*;
#(
  parameter int DICT_TILES = DICT_TILES_DEF,
  parameter int MAX_TILES  = MAX_TILES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  output logic      out_push,
  output result_t   out_res,
  input  wire logic out_full
);
  localparam int DAW = (DICT_TILES > 1) ? $clog2(DICT_TILES) : 1;
  localparam int HAW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

  typedef enum logic [5:0] {
    B_IDLE  = 6'b000001,
    B_TILE  = 6'b000010,
    B_HIST  = 6'b000100,
    B_DICT  = 6'b001000,
    B_EMIT  = 6'b010000,
    B_FLUSH = 6'b100000
  } bstate_t;

  logic [63:0] dict_mem [DICT_TILES];
  logic [9:0]  hist_mem [MAX_TILES];   // {bad, index}
  logic [63:0] dict_q;
  logic [9:0]  hist_q;

  bstate_t          state, state_next;
  logic [POS_W-1:0] tpp, tpp_next;
  logic [7:0]       hgt, hgt_next;
  logic [1:0]       plane, plane_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       col, col_next;
  logic [7:0]       row, row_next;
  logic [4:0]       cnt, cnt_next;
  logic             is_ref, is_ref_next;
  logic [11:0]      offset, offset_next;
  logic [8:0]       idx, idx_next;
  logic             tbad, tbad_next;
  logic             from_hist, from_hist_next;
  logic             emit_done, emit_done_next;
  logic             hold_v, hold_v_next;
  result_t          hold, hold_next;

  logic [8:0]       dict_addr;
  logic [POS_W-1:0] hist_rd;
  logic             dict_we;
  logic             hist_we;
  result_t          res_new;
  logic             can_emit;
  logic [8:0]       row_inc;

  assign dict_addr = (state == B_DICT && from_hist) ? hist_q[8:0] : idx;
  assign hist_rd   = pos - offset[POS_W-1:0];
  assign can_emit  = !hold_v || !out_full;
  assign row_inc   = {1'b0, row} + 9'd1;

  always_comb begin
    res_new              = '0;
    res_new.is_write     = !emit_done;
    res_new.blob_done    = emit_done;
    if (!emit_done) begin
      res_new.bad_token    = tbad || (hgt == '0);
      res_new.tile_address = VRAM_BASE + {plane, 14'b0} - {plane, 13'b0}
                           + {col, 8'b0} + ROW_TOP - {5'b0, row, 3'b0};
      res_new.tile_data    = res_new.bad_token ? 64'd0 : dict_q;
    end
  end

  always_comb begin
    state_next     = state;
    tpp_next       = tpp;
    hgt_next       = hgt;
    plane_next     = plane;
    pos_next       = pos;
    col_next       = col;
    row_next       = row;
    cnt_next       = cnt;
    is_ref_next    = is_ref;
    offset_next    = offset;
    idx_next       = idx;
    tbad_next      = tbad;
    from_hist_next = from_hist;
    emit_done_next = emit_done;
    hold_v_next    = hold_v;
    hold_next      = hold;
    cmd_pop        = 1'b0;
    out_push       = 1'b0;
    out_res        = hold;
    dict_we        = 1'b0;
    hist_we        = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_HDR: begin
              tpp_next   = cmd.tpp;
              hgt_next   = cmd.height;
              plane_next = '0;
              pos_next   = '0;
              col_next   = '0;
              row_next   = '0;
            end
            OP_PLANE: begin
              plane_next = plane + 1'b1;
              pos_next   = '0;
              col_next   = '0;
              row_next   = '0;
            end
            OP_DICT: dict_we = 1'b1;
            OP_LIT: begin
              idx_next    = cmd.idx;
              tbad_next   = cmd.bad;
              is_ref_next = 1'b0;
              cnt_next    = 5'd1;
              state_next  = B_TILE;
            end
            OP_REF: begin
              offset_next = cmd.offset;
              is_ref_next = 1'b1;
              cnt_next    = cmd.len;
              state_next  = B_TILE;
            end
            OP_DONE: begin
              emit_done_next = 1'b1;
              state_next     = B_EMIT;
            end
            OP_EOB: state_next = B_FLUSH;
            default: begin
            end
          endcase
        end
      end
      B_TILE: begin
        emit_done_next = 1'b0;
        from_hist_next = 1'b0;
        if (pos >= tpp) begin
          // past the plane end: no write, position still moves
          pos_next = pos + 1'b1;
          if (hgt != '0) begin
            if (row_inc >= {1'b0, hgt}) begin
              row_next = '0;
              col_next = col + 1'b1;
            end else begin
              row_next = row_inc[7:0];
            end
          end
          cnt_next   = cnt - 1'b1;
          state_next = (cnt == 5'd1) ? B_IDLE : B_TILE;
        end else if (is_ref && (offset == '0 || offset > {1'b0, pos})) begin
          idx_next   = '0;
          tbad_next  = 1'b1;
          state_next = B_DICT;
        end else if (is_ref) begin
          state_next = B_HIST;
        end else begin
          state_next = B_DICT;
        end
      end
      B_HIST: begin
        from_hist_next = 1'b1;
        state_next     = B_DICT;
      end
      B_DICT: begin
        if (from_hist) begin
          idx_next  = hist_q[8:0];
          tbad_next = hist_q[9];
        end
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (can_emit) begin
          if (hold_v) begin
            out_push     = 1'b1;
            out_res      = hold;
            out_res.last = 1'b0;
          end
          hold_v_next = 1'b1;
          hold_next   = res_new;
          if (emit_done) begin
            state_next = B_IDLE;
          end else begin
            hist_we  = 1'b1;
            pos_next = pos + 1'b1;
            if (hgt != '0) begin
              if (row_inc >= {1'b0, hgt}) begin
                row_next = '0;
                col_next = col + 1'b1;
              end else begin
                row_next = row_inc[7:0];
              end
            end
            cnt_next   = cnt - 1'b1;
            state_next = (cnt == 5'd1) ? B_IDLE : B_TILE;
          end
        end
      end
      B_FLUSH: begin
        if (!hold_v) begin
          state_next = B_IDLE;
        end else if (!out_full) begin
          out_push     = 1'b1;
          out_res      = hold;
          out_res.last = 1'b1;
          hold_v_next  = 1'b0;
          state_next   = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      tpp       <= '0;
      hgt       <= '0;
      plane     <= '0;
      pos       <= '0;
      col       <= '0;
      row       <= '0;
      cnt       <= '0;
      is_ref    <= 1'b0;
      from_hist <= 1'b0;
      emit_done <= 1'b0;
      hold_v    <= 1'b0;
    end else begin
      state     <= state_next;
      tpp       <= tpp_next;
      hgt       <= hgt_next;
      plane     <= plane_next;
      pos       <= pos_next;
      col       <= col_next;
      row       <= row_next;
      cnt       <= cnt_next;
      is_ref    <= is_ref_next;
      from_hist <= from_hist_next;
      emit_done <= emit_done_next;
      hold_v    <= hold_v_next;
    end
  end

  always_ff @(posedge clk) begin
    offset <= offset_next;
    idx    <= idx_next;
    tbad   <= tbad_next;
    hold   <= hold_next;
  end

  // dictionary: written from commands, read at the selected index
  always_ff @(posedge clk) begin
    if (dict_we) dict_mem[cmd.entry[DAW-1:0]] <= cmd.data;
    dict_q <= dict_mem[dict_addr[DAW-1:0]];
  end

  // index history: one entry per written position of the current plane
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[pos[HAW-1:0]] <= {tbad, idx};
    hist_q <= hist_mem[hist_rd[HAW-1:0]];
  end
endmodule
`default_nettype wire

// ===== rtl/core/lzt_checker.sv =====
// Port-level checker for the tile stream expander, bound to the top level.
`default_nettype none
`include "lz_tile_stream_expander_macros.svh"
module lzt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        is_write,
  input wire logic [15:0] tile_address,
  input wire logic [63:0] tile_data,
  input wire logic        bad_token,
  input wire logic        blob_done
);
  // done result closes its byte and carries nothing else
  `LZT_ASSERT_IMPLY(a_done_shape, clk, rst, !empty && blob_done, !is_write && tile_address == 16'd0)
  // a result is either a write or the done marker
  `LZT_ASSERT_IMPLY(a_kind, clk, rst, !empty, is_write != blob_done)
  // undecodable tiles write zeros
  `LZT_ASSERT_IMPLY(a_bad_zero, clk, rst, !empty && bad_token, is_write && tile_data == 64'd0)
  // a waiting result stays put
  `LZT_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(tile_address))
endmodule

bind lz_tile_stream_expander lzt_checker u_lzt_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .is_write    (is_write),
  .tile_address(tile_address),
  .tile_data   (tile_data),
  .bad_token   (bad_token),
  .blob_done   (blob_done)
);
`default_nettype wire
